// File: rtl/core/bvwp_pkg.sv
package bvwp_pkg;

  // Default geometry
  localparam int IMAGE_COLS_DEF = 16;
  localparam int IMAGE_ROWS_DEF = 16;
  localparam int VIEW_COLS_DEF  = 8;
  localparam int VIEW_ROWS_DEF  = 8;

  // Signed width for position arithmetic: 8-bit signed operands on positions below 64
  localparam int CLW = 10;

  // Operation codes
  localparam logic [2:0] OP_SET    = 3'd0;
  localparam logic [2:0] OP_MOVE   = 3'd1;
  localparam logic [2:0] OP_CENTER = 3'd2;
  localparam logic [2:0] OP_HOME   = 3'd3;
  localparam logic [2:0] OP_LOAD   = 3'd4;
  localparam logic [2:0] OP_DRAW   = 3'd5;

  // Pattern codes
  localparam logic [2:0] PAT_EMPTY  = 3'd0;
  localparam logic [2:0] PAT_FULL   = 3'd1;
  localparam logic [2:0] PAT_CAL    = 3'd2;
  localparam logic [2:0] PAT_DOT    = 3'd3;
  localparam logic [2:0] PAT_SMILEY = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOAD,
    ST_DRAW_RD,
    ST_DRAW_SEG,
    ST_DRAW_PACK,
    ST_DRAW_EMIT,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic capture;
    logic place_set;
    logic place_move;
    logic center;
    logic home;
    logic load_start;
    logic load_step;
    logic draw_start;
    logic rd_issue;
    logic seg_load;
    logic pack;
    logic emit_draw;
    logic emit_pos;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       pat_ok;
    logic       load_last;
    logic       out_free;
    logic       acc_full;
    logic       acc_empty;
    logic       seg_empty;
    logic       rows_done;
  } status_t;

  // Clamp one axis: reaching the image edge pulls back to image - view - 1,
  // negative goes to 0, and the result never drops below 0.
  function automatic logic [CLW-1:0] clamp_axis(input logic signed [CLW-1:0] p,
                                                input int image, input int view);
    int pi;
    int lim;
    pi  = int'(p);
    lim = image - view - 1;
    if (pi + view >= image) pi = lim;
    else if (pi < 0) pi = 0;
    if (pi < 0) pi = 0;
    return CLW'(pi);
  endfunction

  // One image row of a preset pattern; bit c is column c.
  function automatic logic [63:0] pattern_row(input logic [2:0] pat, input int row,
                                              input int cols, input int hr, input int hc);
    logic [63:0] v;
    logic [63:0] full;
    v    = '0;
    full = (cols >= 64) ? '1 : ((64'(1) << cols) - 64'(1));
    unique case (pat)
      PAT_FULL: v = full;
      PAT_CAL: begin
        if (row == 0) v = 64'(5);
        if (row == 1) v = 64'(1);
      end
      PAT_DOT: begin
        if (row == hr - 1 || row == hr) v = 64'(3) << (hc - 1);
      end
      PAT_SMILEY: begin
        if (row == hr + 2 || row == hr + 3) v = (64'(3) << (hc - 3)) | (64'(3) << (hc + 1));
        if (row == hr - 4 || row == hr - 3) v = 64'(63) << (hc - 3);
      end
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/bvwp_ctrl.sv
module bvwp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bvwp_pkg::status_t status,
  output bvwp_pkg::cmd_t    cmd
);

  bvwp_pkg::state_t state;
  bvwp_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= bvwp_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      bvwp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = bvwp_pkg::ST_EXEC;
        end
      end
      bvwp_pkg::ST_EXEC: begin
        state_next = bvwp_pkg::ST_RESULT;
        unique case (status.op)
          bvwp_pkg::OP_SET:    cmd.place_set  = 1'b1;
          bvwp_pkg::OP_MOVE:   cmd.place_move = 1'b1;
          bvwp_pkg::OP_CENTER: cmd.center     = 1'b1;
          bvwp_pkg::OP_HOME:   cmd.home       = 1'b1;
          bvwp_pkg::OP_LOAD: begin
            if (status.pat_ok) begin
              cmd.load_start = 1'b1;
              state_next     = bvwp_pkg::ST_LOAD;
            end
          end
          bvwp_pkg::OP_DRAW: begin
            cmd.draw_start = 1'b1;
            state_next     = bvwp_pkg::ST_DRAW_RD;
          end
          default: state_next = bvwp_pkg::ST_RESULT;
        endcase
      end
      bvwp_pkg::ST_LOAD: begin
        cmd.load_step = 1'b1;
        if (status.load_last) state_next = bvwp_pkg::ST_RESULT;
      end
      bvwp_pkg::ST_DRAW_RD: begin
        cmd.rd_issue = 1'b1;
        state_next   = bvwp_pkg::ST_DRAW_SEG;
      end
      bvwp_pkg::ST_DRAW_SEG: begin
        cmd.seg_load = 1'b1;
        state_next   = bvwp_pkg::ST_DRAW_PACK;
      end
      bvwp_pkg::ST_DRAW_PACK: begin
        priority if (status.acc_full) state_next = bvwp_pkg::ST_DRAW_EMIT;
        else if (!status.seg_empty) cmd.pack = 1'b1;
        else if (!status.rows_done) state_next = bvwp_pkg::ST_DRAW_RD;
        else if (!status.acc_empty) state_next = bvwp_pkg::ST_DRAW_EMIT;
        else state_next = bvwp_pkg::ST_IDLE;
      end
      bvwp_pkg::ST_DRAW_EMIT: begin
        if (status.out_free) begin
          cmd.emit_draw = 1'b1;
          state_next    = bvwp_pkg::ST_DRAW_PACK;
        end
      end
      bvwp_pkg::ST_RESULT: begin
        if (status.out_free) begin
          cmd.emit_pos = 1'b1;
          state_next   = bvwp_pkg::ST_IDLE;
        end
      end
      default: state_next = bvwp_pkg::ST_IDLE;
    endcase
  end

  // Never emit into a full output register
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_pos || cmd.emit_draw) |-> status.out_free)
    else $error("emit while output register busy");

  // The last load row ends the sweep with a single result
  a_load_end: assert property (@(posedge clk) disable iff (rst)
    (state == bvwp_pkg::ST_LOAD && status.load_last) |=> state == bvwp_pkg::ST_RESULT)
    else $error("load sweep did not finish");

  // An accepted item is always decoded next
  a_capture_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> state == bvwp_pkg::ST_EXEC)
    else $error("accepted item not executed");

endmodule

// File: rtl/core/bvwp_datapath.sv
module bvwp_datapath #(
  parameter int IMAGE_COLS = bvwp_pkg::IMAGE_COLS_DEF,
  parameter int IMAGE_ROWS = bvwp_pkg::IMAGE_ROWS_DEF,
  parameter int VIEW_COLS  = bvwp_pkg::VIEW_COLS_DEF,
  parameter int VIEW_ROWS  = bvwp_pkg::VIEW_ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  bvwp_pkg::cmd_t    cmd,
  output bvwp_pkg::status_t status,
  input  logic [2:0]        operation,
  input  logic signed [7:0] x_value,
  input  logic signed [7:0] y_value,
  input  logic [2:0]        pattern,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [3:0]        window_x,
  output logic [3:0]        window_y,
  output logic [7:0]        window_byte,
  output logic              last_byte
);

  localparam int PXW = $clog2(IMAGE_COLS);
  localparam int PYW = $clog2(IMAGE_ROWS);
  localparam int VRW = $clog2(VIEW_ROWS + 1);
  localparam int SLW = $clog2(VIEW_COLS + 1);
  localparam int ADW = ((PYW > VRW) ? PYW : VRW) + 1;
  localparam int CX_I = (IMAGE_COLS - VIEW_COLS) / 2;
  localparam int CY_I = (IMAGE_ROWS - VIEW_ROWS) / 2;
  localparam logic [PXW-1:0] CX = PXW'((CX_I < 0) ? 0 : CX_I);
  localparam logic [PYW-1:0] CY = PYW'((CY_I < 0) ? 0 : CY_I);
  localparam int HR = IMAGE_ROWS / 2;
  localparam int HC = IMAGE_COLS / 2;

  // Captured item
  logic [2:0]        op_q;
  logic signed [7:0] xv_q;
  logic signed [7:0] yv_q;
  logic [2:0]        pat_q;

  logic [PXW-1:0] col_pos;
  logic [PYW-1:0] row_pos;

  // Image store
  logic [IMAGE_COLS-1:0] pixel_mem [IMAGE_ROWS];
  logic [IMAGE_ROWS-1:0] row_valid;
  logic [PYW-1:0]        load_cnt;
  logic [IMAGE_COLS-1:0] load_row;
  logic [IMAGE_COLS-1:0] rd_data;
  logic                  rd_ok;

  // Draw packer
  logic [VRW-1:0]       vrow;
  logic [ADW-1:0]       rd_addr;
  logic                 rd_in_range;
  logic [VIEW_COLS-1:0] seg;
  logic [SLW-1:0]       seg_left;
  logic [7:0]           acc;
  logic [3:0]           acc_fill;

  // Placement
  logic signed [bvwp_pkg::CLW-1:0] nx;
  logic signed [bvwp_pkg::CLW-1:0] ny;
  logic [bvwp_pkg::CLW-1:0]        cx_clamped;
  logic [bvwp_pkg::CLW-1:0]        cy_clamped;

  always_comb begin
    if (cmd.place_move) begin
      nx = $signed(bvwp_pkg::CLW'(col_pos)) + bvwp_pkg::CLW'(xv_q);
      ny = $signed(bvwp_pkg::CLW'(row_pos)) + bvwp_pkg::CLW'(yv_q);
    end else begin
      nx = bvwp_pkg::CLW'(xv_q);
      ny = bvwp_pkg::CLW'(yv_q);
    end
    cx_clamped = bvwp_pkg::clamp_axis(nx, IMAGE_COLS, VIEW_COLS);
    cy_clamped = bvwp_pkg::clamp_axis(ny, IMAGE_ROWS, VIEW_ROWS);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= operation;
      xv_q  <= x_value;
      yv_q  <= y_value;
      pat_q <= pattern;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (cmd.place_set || cmd.place_move) begin
      col_pos <= cx_clamped[PXW-1:0];
      row_pos <= cy_clamped[PYW-1:0];
    end else if (cmd.center) begin
      col_pos <= CX;
      row_pos <= CY;
    end else if (cmd.home) begin
      col_pos <= '0;
      row_pos <= '0;
    end
  end

  // Pattern load sweep: one row per cycle
  always_comb begin
    logic [63:0] pr;
    pr       = bvwp_pkg::pattern_row(pat_q, int'(load_cnt), IMAGE_COLS, HR, HC);
    load_row = pr[IMAGE_COLS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) load_cnt <= '0;
    else if (cmd.load_start) load_cnt <= '0;
    else if (cmd.load_step) load_cnt <= load_cnt + PYW'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_step) pixel_mem[load_cnt] <= load_row;
  end

  always_ff @(posedge clk) begin
    if (rst) row_valid <= '0;
    else if (cmd.load_step) row_valid[load_cnt] <= 1'b1;
  end

  // Window row read
  assign rd_addr     = ADW'(row_pos) + ADW'(vrow);
  assign rd_in_range = rd_addr < ADW'(IMAGE_ROWS);

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) rd_data <= pixel_mem[rd_addr[PYW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) rd_ok <= 1'b0;
    else if (cmd.rd_issue) rd_ok <= rd_in_range && row_valid[rd_addr[PYW-1:0]];
  end

  // Window slice of the row, first pixel at the top bit
  logic [IMAGE_COLS+VIEW_COLS-1:0] win_ext;
  logic [VIEW_COLS-1:0]            seg_new;

  always_comb begin
    win_ext = {{VIEW_COLS{1'b0}}, rd_data} >> col_pos;
    for (int j = 0; j < VIEW_COLS; j++) begin
      seg_new[VIEW_COLS-1-j] = win_ext[j] & rd_ok;
    end
  end

  // Pack step: move min(room, left) bits from the segment into the byte
  logic [3:0]  room;
  logic [3:0]  take;
  logic [15:0] pack_pair;
  logic [3:0]  pad;

  always_comb begin
    room = 4'd8 - acc_fill;
    if (seg_left < SLW'(room)) take = 4'(seg_left);
    else take = room;
    pack_pair = {acc, seg[VIEW_COLS-1 -: 8]} << take;
    pad       = 4'd8 - acc_fill;
  end

  always_ff @(posedge clk) begin
    if (cmd.seg_load) seg <= seg_new;
    else if (cmd.pack) seg <= seg << take;
    if (cmd.pack) acc <= pack_pair[15:8];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vrow     <= '0;
      seg_left <= '0;
      acc_fill <= '0;
    end else if (cmd.draw_start) begin
      vrow     <= '0;
      seg_left <= '0;
      acc_fill <= '0;
    end else begin
      if (cmd.seg_load) begin
        vrow     <= vrow + VRW'(1);
        seg_left <= SLW'(VIEW_COLS);
      end else if (cmd.pack) begin
        seg_left <= seg_left - SLW'(take);
        acc_fill <= acc_fill + take;
      end else if (cmd.emit_draw) begin
        acc_fill <= '0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.emit_pos || cmd.emit_draw) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_pos || cmd.emit_draw) begin
      window_x <= 4'(col_pos);
      window_y <= 4'(row_pos);
    end
    if (cmd.emit_pos) begin
      window_byte <= '0;
      last_byte   <= 1'b1;
    end else if (cmd.emit_draw) begin
      window_byte <= acc << pad;
      last_byte   <= status.rows_done && status.seg_empty;
    end
  end

  always_comb begin
    status.op        = op_q;
    status.pat_ok    = pat_q <= bvwp_pkg::PAT_SMILEY;
    status.load_last = load_cnt == PYW'(IMAGE_ROWS - 1);
    status.out_free  = !out_valid || out_ready;
    status.acc_full  = acc_fill == 4'd8;
    status.acc_empty = acc_fill == 4'd0;
    status.seg_empty = seg_left == '0;
    status.rows_done = vrow == VRW'(VIEW_ROWS);
  end

  // A partly filled byte goes out only after the last window row
  a_pad_at_end: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_draw && !status.rows_done) |-> status.acc_full)
    else $error("padded byte before end of window");

  // Pack only with room in the byte and bits left in the segment
  a_pack_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.pack |-> (!status.acc_full && !status.seg_empty))
    else $error("pack step with nothing to move");

endmodule

// File: rtl/core/bitmap_viewport_window_packer.sv
// Viewport over a one-bit image of IMAGE_ROWS x IMAGE_COLS pixels. Each
// accepted item is one operation: set or move the VIEW_ROWS x VIEW_COLS window
// (then clamp it: reaching the image edge pulls the corner back to
// image - window - 1, negative goes to 0), center it, return it home, load a
// preset pattern into the image, or draw. Every operation except draw returns
// one item with the new corner, a zero byte and last_byte set. Draw returns the
// window row-major, eight pixels per byte with the first pixel in bit 7, rows
// packed back to back with no padding, the final byte zero-filled in its low
// bits and flagged by last_byte. Pixels past the image edge read as 0. The
// image is blank after reset; row valid bits clear at once, so there is no
// clearing pass. Items are handled one at a time. A pattern load writes the
// image memory in a one-row-per-cycle sweep. A draw decodes the item; then,
// for each window row, it reads the row, loads its segment and packs it into
// the byte step by step, emitting each full byte. The single read port and
// the one-segment byte packer set this order. A result waiting on out_ready
// stalls the draw but not acceptance of the next item after it.
module bitmap_viewport_window_packer #(
  parameter int IMAGE_COLS = bvwp_pkg::IMAGE_COLS_DEF,
  parameter int IMAGE_ROWS = bvwp_pkg::IMAGE_ROWS_DEF,
  parameter int VIEW_COLS  = bvwp_pkg::VIEW_COLS_DEF,
  parameter int VIEW_ROWS  = bvwp_pkg::VIEW_ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        operation,
  input  logic signed [7:0] x_value,
  input  logic signed [7:0] y_value,
  input  logic [2:0]        pattern,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [3:0]        window_x,
  output logic [3:0]        window_y,
  output logic [7:0]        window_byte,
  output logic              last_byte
);

  // Commands from the sequencer, status back from the datapath
  bvwp_pkg::cmd_t    cmd;
  bvwp_pkg::status_t status;

  // Sequencer: decode the item, run the load sweep and the draw loop
  bvwp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: position registers, image memory, byte packer, output register
  bvwp_datapath #(
    .IMAGE_COLS (IMAGE_COLS),
    .IMAGE_ROWS (IMAGE_ROWS),
    .VIEW_COLS  (VIEW_COLS),
    .VIEW_ROWS  (VIEW_ROWS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .operation   (operation),
    .x_value     (x_value),
    .y_value     (y_value),
    .pattern     (pattern),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .window_x    (window_x),
    .window_y    (window_y),
    .window_byte (window_byte),
    .last_byte   (last_byte)
  );

endmodule

// File: bench/tb_bitmap_viewport_window_packer.sv
`timescale 1ns / 100ps

module tb_bitmap_viewport_window_packer;

  localparam int IMG_COLS  = bvwp_pkg::IMAGE_COLS_DEF;
  localparam int IMG_ROWS  = bvwp_pkg::IMAGE_ROWS_DEF;
  localparam int WIN_COLS  = bvwp_pkg::VIEW_COLS_DEF;
  localparam int WIN_ROWS  = bvwp_pkg::VIEW_ROWS_DEF;
  localparam int WIN_BITS  = WIN_COLS * WIN_ROWS;
  localparam int WIN_BYTES = (WIN_BITS + 7) / 8;

  // Codes the package leaves unnamed: spare operations and bad presets.
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam logic [2:0] PAT_BAD5  = 3'd5;
  localparam logic [2:0] PAT_BAD7  = 3'd7;

  localparam int RANDOM_ITEMS = 450;
  // Leave room for one more draw after the last result.
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic [3:0] wx;
    logic [3:0] wy;
    logic [7:0] wb;
    logic       lb;
  } window_result_t;

  typedef struct {
    logic [2:0]        op;
    logic signed [7:0] xv;
    logic signed [7:0] yv;
    logic [2:0]        pat;
    bit                typed;
    logic [3:0]        tx;
    logic [3:0]        ty;
  } window_cmd_t;

  typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_RARE} stall_mode_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [2:0]        operation = bvwp_pkg::OP_SET;
  logic signed [7:0] x_value = '0;
  logic signed [7:0] y_value = '0;
  logic [2:0]        pattern = bvwp_pkg::PAT_EMPTY;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [3:0]        window_x;
  logic [3:0]        window_y;
  logic [7:0]        window_byte;
  logic              last_byte;

  // Typed expectation that travels with the item currently on the bus.
  bit                cur_typed = 1'b0;
  logic [3:0]        cur_tx = '0;
  logic [3:0]        cur_ty = '0;

  // Shadow of the block: image rows (bit c is column c) and window corner.
  logic [IMG_COLS-1:0] image_rows_m [IMG_ROWS];
  int                  view_col;
  int                  view_row;

  window_result_t window_results_q [$];
  window_cmd_t    directed_cmds [$];

  int fail_count   = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int draw_count   = 0;
  int load_count   = 0;

  stall_mode_t stall_mode = RDY_ALWAYS;
  int          mode_left = 0;
  int          phase_cnt = 0;

  bitmap_viewport_window_packer u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .x_value    (x_value),
    .y_value    (y_value),
    .pattern    (pattern),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .window_x   (window_x),
    .window_y   (window_y),
    .window_byte(window_byte),
    .last_byte  (last_byte)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Clamp one axis: reaching the edge pulls back to image - view - 1,
  // negative goes to 0, and nothing ends below 0.
  function automatic int clamp_corner(input int p, input int image, input int view);
    int q;
    q = p;
    if (q + view >= image) q = image - view - 1;
    else if (q < 0) q = 0;
    if (q < 0) q = 0;
    return q;
  endfunction

  function automatic bit pixel_at(input int r, input int c);
    if (r < 0 || r >= IMG_ROWS || c < 0 || c >= IMG_COLS) return 1'b0;
    return image_rows_m[r][c];
  endfunction

  task automatic set_pixel(input int r, input int c);
    if (r >= 0 && r < IMG_ROWS && c >= 0 && c < IMG_COLS) image_rows_m[r][c] = 1'b1;
  endtask

  task automatic load_preset(input logic [2:0] pat);
    int hr;
    int hc;
    hr = IMG_ROWS / 2;
    hc = IMG_COLS / 2;
    // Unknown presets leave the image alone.
    if (pat <= bvwp_pkg::PAT_SMILEY) begin
      for (int i = 0; i < IMG_ROWS; i++)
        image_rows_m[i] = (pat == bvwp_pkg::PAT_FULL) ? '1 : '0;
      case (pat)
        bvwp_pkg::PAT_CAL: begin
          set_pixel(0, 0);
          set_pixel(1, 0);
          set_pixel(0, 2);
        end
        bvwp_pkg::PAT_DOT: begin
          set_pixel(hr - 1, hc - 1);
          set_pixel(hr - 1, hc);
          set_pixel(hr, hc - 1);
          set_pixel(hr, hc);
        end
        bvwp_pkg::PAT_SMILEY: begin
          for (int d = 2; d <= 3; d++) begin
            set_pixel(hr + d, hc - 3);
            set_pixel(hr + d, hc - 2);
            set_pixel(hr + d, hc + 1);
            set_pixel(hr + d, hc + 2);
          end
          for (int i = -3; i <= 2; i++) begin
            set_pixel(hr - 4, hc + i);
            set_pixel(hr - 3, hc + i);
          end
        end
        default: ;
      endcase
    end
  endtask

  // Apply one operation to the shadow and queue the result items it causes.
  task automatic predict_window_op(input logic [2:0] op, input int xv, input int yv,
                                   input logic [2:0] pat);
    window_result_t r;
    int p;
    case (op)
      bvwp_pkg::OP_SET: begin
        view_col = clamp_corner(xv, IMG_COLS, WIN_COLS);
        view_row = clamp_corner(yv, IMG_ROWS, WIN_ROWS);
      end
      bvwp_pkg::OP_MOVE: begin
        view_col = clamp_corner(view_col + xv, IMG_COLS, WIN_COLS);
        view_row = clamp_corner(view_row + yv, IMG_ROWS, WIN_ROWS);
      end
      bvwp_pkg::OP_CENTER: begin
        view_col = (IMG_COLS - WIN_COLS) / 2;
        view_row = (IMG_ROWS - WIN_ROWS) / 2;
        if (view_col < 0) view_col = 0;
        if (view_row < 0) view_row = 0;
      end
      bvwp_pkg::OP_HOME: begin
        view_col = 0;
        view_row = 0;
      end
      bvwp_pkg::OP_LOAD: load_preset(pat);
      default: ;
    endcase
    r.wx = view_col[3:0];
    r.wy = view_row[3:0];
    if (op == bvwp_pkg::OP_DRAW) begin
      for (int k = 0; k < WIN_BYTES; k++) begin
        r.wb = '0;
        for (int b = 0; b < 8; b++) begin
          p = k * 8 + b;
          if (p < WIN_BITS && pixel_at(view_row + p / WIN_COLS, view_col + p % WIN_COLS))
            r.wb[7 - b] = 1'b1;
        end
        r.lb = (k == WIN_BYTES - 1);
        window_results_q.push_back(r);
      end
    end else begin
      r.wb = '0;
      r.lb = 1'b1;
      window_results_q.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic add_cmd(input logic [2:0] op, input int xv, input int yv,
                         input logic [2:0] pat, input bit typed = 1'b0,
                         input int tx = 0, input int ty = 0);
    window_cmd_t c;
    c.op    = op;
    c.xv    = 8'(xv);
    c.yv    = 8'(yv);
    c.pat   = pat;
    c.typed = typed;
    c.tx    = 4'(tx);
    c.ty    = 4'(ty);
    directed_cmds.push_back(c);
  endtask

  // Draws dominate so that every loaded image gets looked at from many corners;
  // positions stay mostly near the legal range, with full-range values mixed in.
  function automatic window_cmd_t random_cmd();
    window_cmd_t c;
    int pick;
    pick    = $urandom_range(0, 99);
    c.xv    = 8'($urandom_range(0, 255));
    c.yv    = 8'($urandom_range(0, 255));
    c.pat   = 3'($urandom_range(0, 7));
    c.typed = 1'b0;
    c.tx    = '0;
    c.ty    = '0;
    if (pick < 20) begin
      c.op = bvwp_pkg::OP_SET;
      if ($urandom_range(0, 2) != 0) begin
        c.xv = 8'(int'($urandom_range(0, 12)) - 2);
        c.yv = 8'(int'($urandom_range(0, 12)) - 2);
      end
    end else if (pick < 35) begin
      c.op = bvwp_pkg::OP_MOVE;
      if ($urandom_range(0, 3) != 0) begin
        c.xv = 8'(int'($urandom_range(0, 8)) - 4);
        c.yv = 8'(int'($urandom_range(0, 8)) - 4);
      end
    end else if (pick < 42) c.op = bvwp_pkg::OP_CENTER;
    else if (pick < 48) c.op = bvwp_pkg::OP_HOME;
    else if (pick < 62) c.op = bvwp_pkg::OP_LOAD;
    else if (pick < 94) c.op = bvwp_pkg::OP_DRAW;
    else c.op = ($urandom_range(0, 1) != 0) ? OP_SPARE6 : OP_SPARE7;
    return c;
  endfunction

  // Put one item on the bus at this edge and hold it until the handshake.
  task automatic send_cmd(input window_cmd_t c);
    in_valid  <= 1'b1;
    operation <= c.op;
    x_value   <= c.xv;
    y_value   <= c.yv;
    pattern   <= c.pat;
    cur_typed <= c.typed;
    cur_tx    <= c.tx;
    cur_ty    <= c.ty;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Bursts of random length, with gaps of random length between them. Called at
  // an edge right after an acceptance, so in_valid gets one assignment per step.
  int burst_left = 0;
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 6);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver stalls: switch between stall styles at random.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    phase_cnt <= phase_cnt + 1;
    if (mode_left == 0) begin
      mode_left  <= $urandom_range(20, 200);
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      RDY_ALWAYS: out_ready <= 1'b1;
      RDY_COIN:   out_ready <= ($urandom_range(0, 1) != 0);
      RDY_SPARSE: out_ready <= (phase_cnt % 5 == 0);
      default:    out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Monitors: the values read here are the ones present just before the edge.
  // ---------------------------------------------------------------------------

  // Predict on acceptance. A typed row still runs the predictor so the shadow
  // keeps up, but its single result is replaced by the typed corner.
  always @(posedge clk) begin
    window_result_t t;
    if (!rst && in_valid && in_ready) begin
      if (operation == bvwp_pkg::OP_DRAW) draw_count++;
      if (operation == bvwp_pkg::OP_LOAD) load_count++;
      predict_window_op(operation, int'(x_value), int'(y_value), pattern);
      if (cur_typed) begin
        void'(window_results_q.pop_back());
        t.wx = cur_tx;
        t.wy = cur_ty;
        t.wb = '0;
        t.lb = 1'b1;
        window_results_q.push_back(t);
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] expv,
                             input logic [31:0] actv);
    if (expv !== actv) begin
      $error("%s: expected %0d, got %0d", name, expv, actv);
      fail_count++;
    end
  endtask

  // Compare each accepted result item with the oldest expectation.
  always @(posedge clk) begin
    window_result_t e;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (window_results_q.size() == 0) begin
        $error("result item with nothing expected: x=%0d y=%0d byte=%02h last=%0d",
               window_x, window_y, window_byte, last_byte);
        fail_count++;
      end else begin
        e = window_results_q.pop_front();
        check_field("window_x", 32'(e.wx), 32'(window_x));
        check_field("window_y", 32'(e.wy), 32'(window_y));
        check_field("window_byte", 32'(e.wb), 32'(window_byte));
        check_field("last_byte", 32'(e.lb), 32'(last_byte));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < IMG_ROWS; i++) image_rows_m[i] = '0;
    view_col = 0;
    view_row = 0;

    // Directed rows: corner extremes typed in, everything else predicted.
    add_cmd(bvwp_pkg::OP_SET, 0, 0, bvwp_pkg::PAT_EMPTY, 1'b1, 0, 0);
    add_cmd(bvwp_pkg::OP_DRAW, 0, 0, bvwp_pkg::PAT_EMPTY);   // blank image after reset
    add_cmd(bvwp_pkg::OP_SET, 127, 127, bvwp_pkg::PAT_FULL, 1'b1, 7, 7);
    add_cmd(bvwp_pkg::OP_SET, -128, -128, bvwp_pkg::PAT_FULL, 1'b1, 0, 0);
    add_cmd(bvwp_pkg::OP_SET, 8, 8, bvwp_pkg::PAT_EMPTY, 1'b1, 7, 7); // edge reached
    add_cmd(bvwp_pkg::OP_SET, 6, -1, bvwp_pkg::PAT_EMPTY, 1'b1, 6, 0);
    add_cmd(bvwp_pkg::OP_MOVE, 127, -128, bvwp_pkg::PAT_EMPTY);
    add_cmd(bvwp_pkg::OP_CENTER, -1, -1, bvwp_pkg::PAT_EMPTY, 1'b1, 4, 4);
    add_cmd(bvwp_pkg::OP_LOAD, 0, 0, bvwp_pkg::PAT_FULL);
    add_cmd(bvwp_pkg::OP_DRAW, 0, 0, bvwp_pkg::PAT_EMPTY);
    add_cmd(bvwp_pkg::OP_HOME, 55, -55, bvwp_pkg::PAT_EMPTY, 1'b1, 0, 0);
    add_cmd(bvwp_pkg::OP_LOAD, 0, 0, bvwp_pkg::PAT_CAL);
    add_cmd(bvwp_pkg::OP_DRAW, 0, 0, bvwp_pkg::PAT_EMPTY);
    add_cmd(bvwp_pkg::OP_LOAD, 0, 0, bvwp_pkg::PAT_DOT);
    add_cmd(bvwp_pkg::OP_CENTER, 0, 0, bvwp_pkg::PAT_EMPTY);
    add_cmd(bvwp_pkg::OP_DRAW, 0, 0, bvwp_pkg::PAT_EMPTY);
    add_cmd(bvwp_pkg::OP_LOAD, 0, 0, bvwp_pkg::PAT_SMILEY);
    add_cmd(bvwp_pkg::OP_DRAW, 0, 0, bvwp_pkg::PAT_EMPTY);
    add_cmd(bvwp_pkg::OP_SET, 7, 7, bvwp_pkg::PAT_EMPTY, 1'b1, 7, 7);
    add_cmd(bvwp_pkg::OP_DRAW, 0, 0, bvwp_pkg::PAT_EMPTY);   // bottom-right corner
    add_cmd(bvwp_pkg::OP_LOAD, 0, 0, PAT_BAD5);               // unknown preset: image kept
    add_cmd(bvwp_pkg::OP_LOAD, 0, 0, PAT_BAD7);
    add_cmd(bvwp_pkg::OP_DRAW, 0, 0, bvwp_pkg::PAT_EMPTY);
    add_cmd(OP_SPARE6, -1, 1, bvwp_pkg::PAT_EMPTY);
    add_cmd(OP_SPARE7, 1, -1, bvwp_pkg::PAT_EMPTY);

    // Hold reset, then release it once.
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_cmds[i]) begin
      send_cmd(directed_cmds[i]);
      pace_sender();
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      send_cmd(random_cmd());
      pace_sender();
    end
    in_valid <= 1'b0;
    // Let the monitor queue the expectations of the last accepted item.
    @(posedge clk);

    // Drain: wait out every expectation, then watch for stray results.
    while (window_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d operations (%0d draws, %0d pattern loads); checked %0d result items.",
             items_sent, draw_count, load_count, results_seen);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches found", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("timeout with %0d result items still expected", window_results_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
